@@ hw/rtl/assert_macros.svh @@
// -----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion shorthands used by the port checker file.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/scp_pkg.sv @@
// -----------------------------------------------------------------------------
// Sine/cosine package
// Shared widths, fixed-point constants, queue item type and arithmetic helpers.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scp_pkg;

  localparam int ANGLE_W   = 48;
  localparam int OUT_W     = 32;
  localparam int POLY_FRAC = 28;
  localparam int POLY_W    = 33;

  // pi and 2*pi with 60 fraction bits
  localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;
  localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;

  localparam int QUEUE_DEPTH = 4;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = Q_PTR_W + 1;

  typedef logic signed [POLY_W-1:0] poly_t;

  localparam poly_t Q_ONE = 33'sd268435456;

  // Horner coefficients, innermost first
  localparam poly_t SIN_COEF [5] = '{33'sd725, 33'sd53258, 33'sd2236961,
                                     33'sd44739244, 33'sd268435456};
  localparam poly_t COS_COEF [5] = '{33'sd74, 33'sd6657, 33'sd372827,
                                     33'sd11184812, 33'sd134217728};

  localparam logic [2*POLY_W-1:0] QMUL_HALF = (2*POLY_W)'(1) << (POLY_FRAC - 1);
  localparam logic signed [POLY_W:0] SAT_MAX = 34'sd2147483647;
  localparam logic signed [POLY_W:0] SAT_MIN = -34'sd2147483648;

  // How an angle gets folded into [-pi, pi]
  typedef enum logic [1:0] {
    RED_NONE = 2'd0,
    RED_UP   = 2'd1,
    RED_DOWN = 2'd2
  } red_kind_t;

  // Classified angle: raw angle for RED_NONE, else |angle +/- pi|
  typedef struct packed {
    red_kind_t            kind;
    logic [ANGLE_W-1:0]   value;
  } red_item_t;

  // Round a Q60 constant to the given number of fraction bits, half up
  function automatic logic [63:0] round_q60(input logic [63:0] v, input int unsigned frac);
    int unsigned sh;
    sh = 60 - frac;
    return (v + (64'd1 << (sh - 1))) >> sh;
  endfunction

  // Q.28 product, rounded to nearest with halves away from zero
  function automatic poly_t qmul(input poly_t a, input poly_t b);
    logic signed [2*POLY_W-1:0] p;
    logic [2*POLY_W-1:0]        mag;
    logic [2*POLY_W-1:0]        rnd;
    logic signed [2*POLY_W-1:0] res;
    p   = a * b;
    mag = p[2*POLY_W-1] ? $unsigned(-p) : $unsigned(p);
    rnd = (mag + QMUL_HALF) >> POLY_FRAC;
    res = p[2*POLY_W-1] ? -$signed(rnd) : $signed(rnd);
    return res[POLY_W-1:0];
  endfunction

  // Double to Q.29 and clamp to the signed 32-bit range
  function automatic logic signed [OUT_W-1:0] sat_out(input poly_t q);
    logic signed [POLY_W:0] v;
    v = {q, 1'b0};
    if (v > SAT_MAX) begin
      v = SAT_MAX;
    end else if (v < SAT_MIN) begin
      v = SAT_MIN;
    end
    return $signed(v[OUT_W-1:0]);
  endfunction

endpackage

@@ hw/rtl/sine_cosine_polynomial.sv @@
// -----------------------------------------------------------------------------
// Sine/cosine by range reduction and Taylor polynomials
// Takes one signed angle in radians (48 bits, ANGLE_FRAC_BITS fraction bits)
// per item and returns its sine and cosine as saturated Q2.29 values in one
// item. The block is fully pipelined and sustains one item per clock while
// out_ready stays high. An accepted item moves from the input stage into the
// queue, then through the range reduction (capture, reciprocal multiply for
// the quotient, multiply and subtract for the remainder, one correction step,
// fold around zero) and the polynomial pipeline, output register included.
// A stalled result holds the whole back end; the queue (four items) and the
// input stage (one item) then fill before in_ready drops. There is no state
// between items and no start-up pass after reset.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sine_cosine_polynomial #(
  parameter int ANGLE_FRAC_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [scp_pkg::ANGLE_W-1:0] in_angle,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [scp_pkg::OUT_W-1:0]   out_sine,
  output logic signed [scp_pkg::OUT_W-1:0]   out_cosine
);
  import scp_pkg::*;

  // Front end to queue
  logic      q_full;
  logic      q_empty;
  logic      q_push;
  logic      q_pop;
  red_item_t q_push_item;
  red_item_t q_head;

  // Back end
  logic  back_adv;
  logic  x_valid;
  poly_t x_q28;

  // Front end: classify each angle and hand it to the queue. in_ready only
  // looks at the staging register and the queue fill, so it never waits on
  // out_ready.
  scp_front #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_angle  (in_angle),
    .q_full    (q_full),
    .push      (q_push),
    .push_item (q_push_item)
  );

  scp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  // Back end advances as one unit whenever the output register is free or
  // being drained; hold every stage otherwise. Pop the queue on each advance
  // that finds an item waiting, else let a bubble in.
  assign back_adv = !out_valid || out_ready;
  assign q_pop    = back_adv && !q_empty;

  scp_reduce #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_reduce (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (back_adv),
    .head_valid (!q_empty),
    .head       (q_head),
    .x_valid    (x_valid),
    .x_q28      (x_q28)
  );

  // Polynomial stages end in the output register that drives the result port
  scp_poly u_poly (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (back_adv),
    .x_valid    (x_valid),
    .x_q28      (x_q28),
    .out_valid  (out_valid),
    .out_sine   (out_sine),
    .out_cosine (out_cosine)
  );

endmodule

@@ hw/rtl/scp_front.sv @@
// -----------------------------------------------------------------------------
// Sine/cosine front end
// Accepts angles, classifies the fold needed and stages one item for the queue.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scp_front #(
  parameter int ANGLE_FRAC_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [scp_pkg::ANGLE_W-1:0]  in_angle,
  input  logic                                q_full,
  output logic                                push,
  output scp_pkg::red_item_t                  push_item
);
  import scp_pkg::*;

  localparam logic [63:0] PI_F = round_q60(PI_Q60, ANGLE_FRAC_BITS);
  localparam logic signed [ANGLE_W-1:0] PI_A = PI_F[ANGLE_W-1:0];

  logic      fr_valid_r;
  red_item_t fr_item_r;
  red_item_t fr_item_nxt;
  logic      fr_adv;

  // Classify: angles beyond +/-pi carry the magnitude to be reduced
  always_comb begin
    if (in_angle > PI_A) begin
      fr_item_nxt.kind  = RED_UP;
      fr_item_nxt.value = $unsigned(in_angle + PI_A);
    end else if (in_angle < -PI_A) begin
      fr_item_nxt.kind  = RED_DOWN;
      fr_item_nxt.value = $unsigned(PI_A - in_angle);
    end else begin
      fr_item_nxt.kind  = RED_NONE;
      fr_item_nxt.value = $unsigned(in_angle);
    end
  end

  assign fr_adv    = !fr_valid_r || !q_full;
  assign in_ready  = fr_adv;
  assign push      = fr_valid_r && !q_full;
  assign push_item = fr_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else if (fr_adv) begin
      fr_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fr_adv && in_valid) begin
      fr_item_r <= fr_item_nxt;
    end
  end

endmodule

@@ hw/rtl/scp_queue.sv @@
// -----------------------------------------------------------------------------
// Sine/cosine item queue
// Small FIFO between front end and back end.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  scp_pkg::red_item_t push_item,
  input  logic               pop,
  output logic               full,
  output logic               empty,
  output scp_pkg::red_item_t head
);
  import scp_pkg::*;

  red_item_t          entries_r [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r;
  logic [Q_CNT_W-1:0] count_nxt;

  assign full      = (count_r == Q_CNT_W'(QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign head      = entries_r[rd_ptr_r];
  assign count_nxt = count_r + Q_CNT_W'(push) - Q_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ hw/rtl/scp_reduce.sv @@
// -----------------------------------------------------------------------------
// Sine/cosine range reduction
// Remainder by 2*pi from a reciprocal multiply and one correction, then fold.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scp_reduce #(
  parameter int ANGLE_FRAC_BITS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               head_valid,
  input  scp_pkg::red_item_t head,
  output logic               x_valid,
  output scp_pkg::poly_t     x_q28
);
  import scp_pkg::*;

  localparam logic [63:0] PI_F     = round_q60(PI_Q60, ANGLE_FRAC_BITS);
  localparam logic [63:0] TWO_PI_F = round_q60(TWO_PI_Q60, ANGLE_FRAC_BITS);
  localparam int DW     = $clog2(TWO_PI_F + 64'd1);
  localparam int QW     = ANGLE_W - DW + 1;
  localparam int RW     = DW + 2;
  localparam int XW     = DW + 1;
  localparam int RCP_SH = 31;
  localparam int PW     = QW + RCP_SH;
  localparam int NST    = 4;
  localparam logic [127:0] RCP_FULL =
    (128'd1 << (DW - 1 + RCP_SH)) / {64'd0, TWO_PI_F};
  localparam logic [31:0]          RCP  = RCP_FULL[31:0];
  localparam logic [RW-1:0]        D_R  = TWO_PI_F[RW-1:0];
  localparam logic [RW-1:0]        D2_R = D_R << 1;
  localparam logic signed [XW-1:0] PI_X = PI_F[XW-1:0];

  logic                 vld_r  [NST];
  red_kind_t            kind_r [NST];
  logic signed [XW-1:0] none_r [NST];

  logic [ANGLE_W-1:0]   val_r;
  logic [QW-1:0]        quo_r;
  logic [RW-1:0]        vlo_r;
  logic [RW-1:0]        rsd_r;
  logic [DW-1:0]        rem_r;
  logic [PW-1:0]        quo_prod;
  logic [RW-1:0]        quo_mul;
  logic [RW-1:0]        rsd_nxt;
  logic [RW-1:0]        rem_nxt;

  logic                 xv_r;
  logic signed [XW-1:0] xa_r;
  logic signed [XW-1:0] xa_nxt;

  // Quotient estimate from the bits at and above the order of 2*pi; it is
  // never above the exact quotient and at most two below it
  assign quo_prod = PW'(val_r[ANGLE_W-1 -: QW]) * PW'(RCP);

  // Remainder of the estimate, kept modulo 2^RW; it lies in [0, 3*D)
  assign quo_mul = RW'(quo_r) * D_R;
  assign rsd_nxt = vlo_r - quo_mul;

  // Drop the one or two extra multiples of 2*pi
  always_comb begin
    if (rsd_r >= D2_R) begin
      rem_nxt = rsd_r - D2_R;
    end else if (rsd_r >= D_R) begin
      rem_nxt = rsd_r - D_R;
    end else begin
      rem_nxt = rsd_r;
    end
  end

  // Fold the remainder back around zero
  always_comb begin
    unique case (kind_r[NST-1])
      RED_UP:   xa_nxt = $signed({1'b0, rem_r}) - PI_X;
      RED_DOWN: xa_nxt = PI_X - $signed({1'b0, rem_r});
      default:  xa_nxt = none_r[NST-1];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NST; i++) begin
        vld_r[i] <= 1'b0;
      end
      xv_r <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= head_valid;
      for (int i = 1; i < NST; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
      xv_r <= vld_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind_r[0] <= head.kind;
      none_r[0] <= $signed(head.value[XW-1:0]);
      val_r     <= head.value;
      for (int i = 1; i < NST; i++) begin
        kind_r[i] <= kind_r[i-1];
        none_r[i] <= none_r[i-1];
      end
      quo_r <= quo_prod[PW-1 -: QW];
      vlo_r <= val_r[RW-1:0];
      rsd_r <= rsd_nxt;
      rem_r <= rem_nxt[DW-1:0];
      xa_r  <= xa_nxt;
    end
  end

  assign x_valid = xv_r;

  // Move to 28 fraction bits
  if (ANGLE_FRAC_BITS <= POLY_FRAC) begin : g_up
    localparam int LSH = POLY_FRAC - ANGLE_FRAC_BITS;
    assign x_q28 = POLY_W'(xa_r) <<< LSH;
  end else begin : g_dn
    localparam int RSH = ANGLE_FRAC_BITS - POLY_FRAC;
    logic          neg;
    logic [XW-1:0] mag;
    logic [XW-1:0] rnd;
    assign neg   = xa_r[XW-1];
    assign mag   = neg ? $unsigned(-xa_r) : $unsigned(xa_r);
    assign rnd   = (mag + (XW'(1) << (RSH - 1))) >> RSH;
    assign x_q28 = neg ? -$signed(POLY_W'(rnd)) : $signed(POLY_W'(rnd));
  end

endmodule

@@ hw/rtl/scp_poly.sv @@
// -----------------------------------------------------------------------------
// Sine/cosine polynomial pipeline
// Horner evaluation of both series, one multiply per series per stage, saturated output.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scp_poly (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              x_valid,
  input  scp_pkg::poly_t                    x_q28,
  output logic                              out_valid,
  output logic signed [scp_pkg::OUT_W-1:0]  out_sine,
  output logic signed [scp_pkg::OUT_W-1:0]  out_cosine
);
  import scp_pkg::*;

  logic  vld_r [7];
  poly_t x_r   [0:5];
  poly_t x2_r  [1:5];
  poly_t ts_r  [2:5];
  poly_t tc_r  [2:5];
  poly_t ts_nxt [2:5];
  poly_t tc_nxt [2:5];
  poly_t x2_nxt;
  poly_t s_r;
  poly_t c_r;
  poly_t s_nxt;
  poly_t c_nxt;

  logic                    out_valid_r;
  logic signed [OUT_W-1:0] out_sine_r;
  logic signed [OUT_W-1:0] out_cosine_r;

  assign x2_nxt = qmul(x_r[0], x_r[0]);

  for (genvar k = 2; k <= 5; k++) begin : g_horner
    if (k == 2) begin : g_first
      assign ts_nxt[k] = SIN_COEF[1] - qmul(x2_r[1], SIN_COEF[0]);
      assign tc_nxt[k] = COS_COEF[1] - qmul(x2_r[1], COS_COEF[0]);
    end else begin : g_next
      assign ts_nxt[k] = SIN_COEF[k-1] - qmul(x2_r[k-1], ts_r[k-1]);
      assign tc_nxt[k] = COS_COEF[k-1] - qmul(x2_r[k-1], tc_r[k-1]);
    end
  end

  assign s_nxt = qmul(x_r[5], ts_r[5]);
  assign c_nxt = Q_ONE - qmul(x2_r[5], tc_r[5]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 7; i++) begin
        vld_r[i] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= x_valid;
      for (int i = 1; i < 7; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
      out_valid_r <= vld_r[6];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r[0]  <= x_q28;
      for (int i = 1; i <= 5; i++) begin
        x_r[i] <= x_r[i-1];
      end
      x2_r[1] <= x2_nxt;
      for (int i = 2; i <= 5; i++) begin
        x2_r[i] <= x2_r[i-1];
        ts_r[i] <= ts_nxt[i];
        tc_r[i] <= tc_nxt[i];
      end
      s_r          <= s_nxt;
      c_r          <= c_nxt;
      out_sine_r   <= sat_out(s_r);
      out_cosine_r <= sat_out(c_r);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sine   = out_sine_r;
  assign out_cosine = out_cosine_r;

endmodule

@@ hw/rtl/scp_checker.sv @@
// -----------------------------------------------------------------------------
// Sine/cosine port checker
// Watches the result port of the top level over time.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scp_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [scp_pkg::OUT_W-1:0]  out_sine,
  input logic signed [scp_pkg::OUT_W-1:0]  out_cosine
);
  import scp_pkg::*;

  // Folded angles keep both series within about 1.008 in magnitude
  localparam int SAT_LIM = 2**29 + 2**22;

  `ASSERT_CLK_ALWAYS(a_no_result_after_reset, clk, !rst_n |=> !out_valid, "result valid right after reset")
  `ASSERT_CLK(a_result_holds, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_sine) && $stable(out_cosine), "stalled result changed")
  `ASSERT_CLK(a_sine_bounded, clk, rst_n, out_valid |-> (out_sine <= SAT_LIM) && (out_sine >= -SAT_LIM), "sine out of range")
  `ASSERT_CLK(a_cosine_bounded, clk, rst_n, out_valid |-> (out_cosine <= SAT_LIM) && (out_cosine >= -SAT_LIM), "cosine out of range")

endmodule

bind sine_cosine_polynomial scp_checker u_scp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_sine   (out_sine),
  .out_cosine (out_cosine)
);

@@ tb/sine_cosine_polynomial_tb.sv @@
// -----------------------------------------------------------------------------
// Sine/cosine polynomial testbench
// Feeds signed Q23.24 angles through the valid/ready input channel and checks
// every sine/cosine item that comes back. The expected values come from a
// software version of the reduction and Horner polynomials kept in this file.
// It starts with a table of hand-picked angles, then runs random angles with
// random idling on both sides, one long receiver hold-off and drain pauses.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sine_cosine_polynomial_tb;

  localparam int ANGLE_W = scp_pkg::ANGLE_W;
  localparam int OUT_W   = scp_pkg::OUT_W;

  // Fixed-point formats of the checker's own arithmetic
  localparam int ANGLE_FRAC     = 24;
  localparam int POLY_FRAC_BITS = 28;

  // pi and 2*pi with 60 fraction bits
  localparam logic [63:0] PI_Q60_BITS     = 64'h3243F6A8885A308D;
  localparam logic [63:0] TWO_PI_Q60_BITS = 64'h6487ED5110B4611A;

  // Horner coefficients in Q.28
  localparam longint ONE_Q28 = 64'sd268435456;
  localparam longint SIN_K3  = 64'sd44739244;
  localparam longint SIN_K5  = 64'sd2236961;
  localparam longint SIN_K7  = 64'sd53258;
  localparam longint SIN_K9  = 64'sd725;
  localparam longint COS_K2  = 64'sd134217728;
  localparam longint COS_K4  = 64'sd11184812;
  localparam longint COS_K6  = 64'sd372827;
  localparam longint COS_K8  = 64'sd6657;
  localparam longint COS_K10 = 64'sd74;

  // Run control
  localparam int PIPE_DRAIN   = 40;      // well over the pipeline latency
  localparam int HOLD_CYCLES  = 150;     // long enough to back up the pipe
  localparam int CYCLE_LIMIT  = 200000;
  localparam int IDLE_PERCENT = 34;
  localparam int BURST_ITEMS  = 80;
  localparam int MIXED_ITEMS  = 570;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic signed [OUT_W-1:0] sine;
    logic signed [OUT_W-1:0] cosine;
  } trig_pair_t;

  // One row of the directed table; known = 1 when the result is typed in
  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic                      known;
    logic signed [OUT_W-1:0]   sine;
    logic signed [OUT_W-1:0]   cosine;
  } angle_row_t;

  logic                      clk        = 1'b0;
  logic                      rst_n      = 1'b0;
  logic                      in_valid   = 1'b0;
  logic                      in_ready;
  logic signed [ANGLE_W-1:0] in_angle   = '0;
  logic                      out_valid;
  logic                      out_ready  = 1'b0;
  logic signed [OUT_W-1:0]   out_sine;
  logic signed [OUT_W-1:0]   out_cosine;

  trig_pair_t pending_trig [$];
  int         mismatches   = 0;
  int         cycle_count  = 0;
  bit         tx_throttle  = 1'b0;
  bit         rx_throttle  = 1'b0;
  bit         rx_hold_req  = 1'b0;
  int         rx_hold_left = 0;

  // pi at the angle scale is 52707179, 2*pi is 105414357. Rows around the
  // fold points check the exact-pi case (left alone) and the quotient steps.
  angle_row_t directed_rows [20] = '{
    '{48'sd0,            1'b1, 32'sd0,   32'sd536870912},
    '{48'sd1,            1'b1, 32'sd32,  32'sd536870912},
    '{-48'sd1,           1'b1, -32'sd32, 32'sd536870912},
    '{48'sd52707179,     1'b0, 32'sd0,   32'sd0},
    '{-48'sd52707179,    1'b0, 32'sd0,   32'sd0},
    '{48'sd52707180,     1'b0, 32'sd0,   32'sd0},
    '{-48'sd52707180,    1'b0, 32'sd0,   32'sd0},
    '{48'sd52707178,     1'b0, 32'sd0,   32'sd0},
    '{48'sd26353589,     1'b0, 32'sd0,   32'sd0},
    '{-48'sd26353589,    1'b0, 32'sd0,   32'sd0},
    '{48'sd105414357,    1'b0, 32'sd0,   32'sd0},
    '{-48'sd105414357,   1'b0, 32'sd0,   32'sd0},
    '{48'sd158121534,    1'b0, 32'sd0,   32'sd0},
    '{48'sd158121535,    1'b0, 32'sd0,   32'sd0},
    '{-48'sd158121534,   1'b0, 32'sd0,   32'sd0},
    '{-48'sd158121535,   1'b0, 32'sd0,   32'sd0},
    '{48'sh7FFFFFFFFFFF, 1'b0, 32'sd0,   32'sd0},
    '{48'sh800000000000, 1'b0, 32'sd0,   32'sd0},
    '{48'sh555555555555, 1'b0, 32'sd0,   32'sd0},
    '{48'shAAAAAAAAAAAA, 1'b0, 32'sd0,   32'sd0}
  };

  sine_cosine_polynomial uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_angle  (in_angle),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_sine  (out_sine),
    .out_cosine(out_cosine)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Fixed-point arithmetic of the checker
  // ---------------------------------------------------------------------------

  // Bring a Q60 constant down to the angle scale, rounding half up
  function automatic longint to_angle_scale(input logic [63:0] q60);
    logic [63:0] half;
    half = 64'd1 << (59 - ANGLE_FRAC);
    return longint'((q60 + half) >> (60 - ANGLE_FRAC));
  endfunction

  // Right shift with round to nearest, halves away from zero
  function automatic longint round_shr(input longint v, input int sh);
    longint unsigned mag;
    if (sh == 0) begin
      return v;
    end
    mag = (v < 0) ? longint'(-v) : longint'(v);
    mag = (mag + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint fx_mul(input longint a, input longint b);
    return round_shr(a * b, POLY_FRAC_BITS);
  endfunction

  // Q.28 to Q2.29, clamped to 32 bits
  function automatic logic signed [OUT_W-1:0] to_q29(input longint q);
    longint v;
    v = q * 2;
    if (v > 64'sd2147483647) begin
      v = 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      v = -64'sd2147483648;
    end
    return v[OUT_W-1:0];
  endfunction

  // Fold the angle into [-pi, pi], then run both Horner chains
  function automatic trig_pair_t sincos_expected(input logic signed [ANGLE_W-1:0] angle);
    longint     pi_a;
    longint     two_pi_a;
    longint     a;
    longint     x;
    longint     x2;
    longint     t;
    longint     s;
    longint     c;
    trig_pair_t r;
    pi_a     = to_angle_scale(PI_Q60_BITS);
    two_pi_a = to_angle_scale(TWO_PI_Q60_BITS);
    a        = longint'(angle);
    // Exactly +/-pi falls through untouched; division truncates toward zero
    if (a > pi_a) begin
      a -= ((a + pi_a) / two_pi_a) * two_pi_a;
    end else if (a < -pi_a) begin
      a -= ((a - pi_a) / two_pi_a) * two_pi_a;
    end
    x  = a <<< (POLY_FRAC_BITS - ANGLE_FRAC);
    x2 = fx_mul(x, x);

    t = SIN_K9;
    t = SIN_K7 - fx_mul(x2, t);
    t = SIN_K5 - fx_mul(x2, t);
    t = SIN_K3 - fx_mul(x2, t);
    t = ONE_Q28 - fx_mul(x2, t);
    s = fx_mul(x, t);

    t = COS_K10;
    t = COS_K8 - fx_mul(x2, t);
    t = COS_K6 - fx_mul(x2, t);
    t = COS_K4 - fx_mul(x2, t);
    t = COS_K2 - fx_mul(x2, t);
    c = ONE_Q28 - fx_mul(x2, t);

    r.sine   = to_q29(s);
    r.cosine = to_q29(c);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Random angles: full-width noise, the principal range, fold boundaries,
  // tiny values, values near the 48-bit extremes and mid-size values
  // ---------------------------------------------------------------------------
  function automatic logic signed [ANGLE_W-1:0] random_angle();
    longint pi_a;
    longint two_pi_a;
    longint v;
    int     pick;
    pi_a     = to_angle_scale(PI_Q60_BITS);
    two_pi_a = to_angle_scale(TWO_PI_Q60_BITS);
    pick     = $urandom_range(0, 9);
    case (pick)
      0, 1, 2: begin
        v = longint'({$urandom, $urandom});
      end
      3, 4, 5: begin
        v = longint'($urandom_range(0, 2 * 52707179)) - pi_a;
      end
      6: begin
        // pi + k*2*pi with a few steps either side
        v = longint'($urandom_range(0, 1000000)) * two_pi_a + pi_a
            + longint'($urandom_range(0, 8)) - 4;
        if ($urandom_range(0, 1) == 1) begin
          v = -v;
        end
      end
      7: begin
        v = longint'($urandom_range(0, 255));
        if ($urandom_range(0, 1) == 1) begin
          v = -v;
        end
      end
      8: begin
        v = longint'($urandom_range(0, 4095));
        v = ($urandom_range(0, 1) == 1) ? (64'sd140737488355327 - v)
                                       : (-64'sd140737488355328 + v);
      end
      default: begin
        v = longint'($signed($urandom));
      end
    endcase
    return v[ANGLE_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: offer one item, hold it until taken, then queue its result
  // ---------------------------------------------------------------------------
  task automatic send_angle(input logic signed [ANGLE_W-1:0] angle, input logic known,
                            input logic signed [OUT_W-1:0] sine_val,
                            input logic signed [OUT_W-1:0] cosine_val);
    trig_pair_t want;
    if (known) begin
      want.sine   = sine_val;
      want.cosine = cosine_val;
    end else begin
      want = sincos_expected(angle);
    end
    // Drop valid for a random number of cycles when throttled
    while (tx_throttle && ($urandom_range(0, 99) < IDLE_PERCENT)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_angle <= angle;
    do begin
      @(posedge clk);
    end while (!in_ready);
    pending_trig.push_back(want);
  endtask

  // Lower valid and hold until every queued result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    wait (pending_trig.size() == 0);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random back-pressure, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rx_hold_req) begin
      rx_hold_left = HOLD_CYCLES;
      rx_hold_req  = 1'b0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else if (rx_throttle) begin
      out_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic note_mismatch(input string field, input logic signed [OUT_W-1:0] want,
                               input logic signed [OUT_W-1:0] got);
    mismatches++;
    if (mismatches <= REPORT_MAX) begin
      $display("mismatch on %s at %0t: expected %0d, got %0d", field, $time, want, got);
    end
  endtask

  // Compare each accepted result with the oldest queued expectation
  always @(posedge clk) begin
    trig_pair_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_trig.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("unexpected result at %0t: sine %0d, cosine %0d", $time, out_sine,
                   out_cosine);
        end
      end else begin
        want = pending_trig.pop_front();
        if (out_sine !== want.sine) begin
          note_mismatch("sine", want.sine, out_sine);
        end
        if (out_cosine !== want.cosine) begin
          note_mismatch("cosine", want.cosine, out_cosine);
        end
      end
    end
  end

  // Watchdog: end the run if it hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_trig.size());
      $display("sine_cosine_polynomial regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned n;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, with idling on both sides
    tx_throttle = 1'b1;
    rx_throttle = 1'b1;
    foreach (directed_rows[row]) begin
      send_angle(directed_rows[row].angle, directed_rows[row].known,
                 directed_rows[row].sine, directed_rows[row].cosine);
    end
    drain_results();

    // Burst: no idling, but the receiver stalls long enough to fill the
    // pipeline and push back on the input
    tx_throttle = 1'b0;
    rx_throttle = 1'b0;
    rx_hold_req = 1'b1;
    for (n = 0; n < BURST_ITEMS; n++) begin
      send_angle(random_angle(), 1'b0, '0, '0);
    end

    // Mixed traffic with random idling, and one drain halfway through
    tx_throttle = 1'b1;
    rx_throttle = 1'b1;
    for (n = 0; n < MIXED_ITEMS; n++) begin
      if (n == MIXED_ITEMS / 2) begin
        drain_results();
      end
      send_angle(random_angle(), 1'b0, '0, '0);
    end

    // Wait for the last results, then watch a while for stray ones
    drain_results();
    repeat (PIPE_DRAIN) @(posedge clk);

    if (mismatches == 0 && pending_trig.size() == 0) begin
      $display("sine_cosine_polynomial regression: pass");
    end else begin
      $display("sine_cosine_polynomial regression: fail");
    end
    $finish;
  end

endmodule
